// ----- design/usbsrr_pkg.sv -----
// Shared types and constants for the USB standard request responder.
// No dependencies; imported by the responder and its port checker.
`timescale 1ns / 1ps

package usbsrr_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SELF_POWERED  = 3'd0,
    CFG_CONFIG_NUMBER = 3'd1,
    CFG_IFACE_NUMBER  = 3'd2,
    CFG_ALT_SETTING   = 3'd3,
    CFG_IN_EP_ADDRESS = 3'd4
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic       SELF_POWERED_RST  = 1'b0;
  localparam logic [7:0] CONFIG_NUMBER_RST = 8'd1;
  localparam logic [7:0] IFACE_NUMBER_RST  = 8'd0;
  localparam logic [7:0] ALT_SETTING_RST   = 8'd0;
  localparam logic [7:0] IN_EP_ADDRESS_RST = 8'd129;

  // Reply kinds
  typedef enum logic [1:0] {
    KIND_STALL   = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_HANDOFF = 2'd3
  } reply_kind_t;

  // Reply lengths
  localparam logic [1:0] LEN_NONE   = 2'd0;
  localparam logic [1:0] LEN_BYTE   = 2'd1;
  localparam logic [1:0] LEN_STATUS = 2'd2;

  // bmRequestType fields
  localparam logic [1:0] TYPE_STANDARD  = 2'b00;
  localparam logic [4:0] RECIP_DEVICE   = 5'd0;
  localparam logic [4:0] RECIP_IFACE    = 5'd1;
  localparam logic [4:0] RECIP_ENDPOINT = 5'd2;

  // Standard request codes
  localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE  = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE  = 8'd11;

  // Feature selectors
  localparam logic [7:0] FEAT_ENDPOINT_HALT = 8'd0;
  localparam logic [7:0] FEAT_REMOTE_WAKEUP = 8'd1;
  localparam logic [7:0] FEAT_TEST_MODE     = 8'd2;

  // Halt slots: endpoint 0, endpoint 1-in, endpoint 1-out
  localparam int HALT_SLOTS = 3;
  localparam logic [1:0] SLOT_EP0    = 2'd0;
  localparam logic [1:0] SLOT_EP1_IN = 2'd1;
  localparam logic [1:0] SLOT_EP1_OUT = 2'd2;

  // Decoded answer to one request
  typedef struct packed {
    reply_kind_t kind;
    logic [1:0]  length;
    logic [7:0]  first;
    logic        toggle_reset;
    logic [7:0]  toggle_endpoint;
    logic        in_endpoint_reset;
  } reply_t;

endpackage

// ----- design/usb_standard_request_responder.sv -----
// USB standard request responder: decodes one control setup request and answers it.
// Depends on usbsrr_pkg.
`timescale 1ns / 1ps

// Takes one setup request per cycle while in_stall is low and returns one reply
// per request, in order. A request is registered on entry, decoded in a single
// pass of combinational logic against the remote-wakeup flag, the three endpoint
// halt bits and the configuration registers, and the reply lands in a result
// register: out_valid rises when the request moves from the input register into
// the result register. Throughput is one request per cycle while nothing stalls,
// set by the input register and the result register each holding one request. A
// stall on the result side holds the result register and then the input register
// behind it. Only standard requests are served; anything else, and any malformed
// standard request, gets a stall reply with all other fields zero and no state
// change. Descriptor lookup is not done here: get descriptor is handed off.
// Write configuration only while the block is idle.
module usb_standard_request_responder (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [usbsrr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [usbsrr_pkg::CFG_DATA_W-1:0]  cfg_data,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_request_type,
  input  logic [7:0]                         in_request_code,
  input  logic [7:0]                         in_value_low,
  input  logic [7:0]                         in_index_low,
  // reply channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_reply_kind,
  output logic [1:0]                         out_reply_length,
  output logic [7:0]                         out_reply_first,
  output logic [7:0]                         out_reply_second,
  output logic                               out_toggle_reset,
  output logic [7:0]                         out_toggle_endpoint,
  output logic                               out_in_endpoint_reset
);

  import usbsrr_pkg::*;

  // configuration registers
  logic       self_powered_r;
  logic [7:0] config_number_r;
  logic [7:0] iface_number_r;
  logic [7:0] alt_setting_r;
  logic [7:0] in_ep_address_r;

  // device state
  logic                  remote_wakeup_r, remote_wakeup_nxt;
  logic [HALT_SLOTS-1:0] halt_r, halt_nxt;

  // input register
  logic       req_valid_r;
  logic [7:0] req_type_r, req_code_r, req_value_r, req_index_r;

  // result register
  logic   rsp_valid_r;
  reply_t rsp_r, rsp_nxt;

  logic out_free;
  logic advance;
  logic take_in;

  // decode helpers
  logic [4:0] recip;
  logic       is_standard;
  logic       slot_ok;
  logic [1:0] slot;

  // The result register frees up when empty or when its reply leaves this edge.
  assign out_free = !rsp_valid_r || !out_stall;
  assign advance  = req_valid_r && out_free;
  assign in_stall = req_valid_r && !out_free;
  assign take_in  = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Configuration writes; indexes past the list are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_powered_r  <= SELF_POWERED_RST;
      config_number_r <= CONFIG_NUMBER_RST;
      iface_number_r  <= IFACE_NUMBER_RST;
      alt_setting_r   <= ALT_SETTING_RST;
      in_ep_address_r <= IN_EP_ADDRESS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SELF_POWERED:  self_powered_r  <= cfg_data[0];
        CFG_CONFIG_NUMBER: config_number_r <= cfg_data;
        CFG_IFACE_NUMBER:  iface_number_r  <= cfg_data;
        CFG_ALT_SETTING:   alt_setting_r   <= cfg_data;
        CFG_IN_EP_ADDRESS: in_ep_address_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: load on accept, hold while the decode stage is blocked.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (take_in) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      req_type_r  <= in_request_type;
      req_code_r  <= in_request_code;
      req_value_r <= in_value_low;
      req_index_r <= in_index_low;
    end
  end

  // ---------------------------------------------------------------------------
  // Endpoint lookup: bit 7 gives direction, the low seven bits the number.
  // Only endpoint 0 and endpoint 1 in either direction have a halt bit.
  // ---------------------------------------------------------------------------
  always_comb begin
    slot_ok = 1'b1;
    slot    = SLOT_EP0;
    if (req_index_r[6:0] == 7'd0) begin
      slot = SLOT_EP0;
    end else if (req_index_r[6:0] == 7'd1) begin
      slot = req_index_r[7] ? SLOT_EP1_IN : SLOT_EP1_OUT;
    end else begin
      slot_ok = 1'b0;
    end
  end

  assign recip       = req_type_r[4:0];
  assign is_standard = (req_type_r[6:5] == TYPE_STANDARD);

  // ---------------------------------------------------------------------------
  // Request decode. Start from a stall reply with everything zero and fill in
  // the fields for each request that is well formed.
  // ---------------------------------------------------------------------------
  always_comb begin
    rsp_nxt           = '0;
    rsp_nxt.kind      = KIND_STALL;
    remote_wakeup_nxt = remote_wakeup_r;
    halt_nxt          = halt_r;

    if (is_standard) begin
      unique case (req_code_r)
        REQ_GET_STATUS: begin
          // needs the to-host direction
          if (req_type_r[7]) begin
            if (recip == RECIP_DEVICE) begin
              rsp_nxt.kind   = KIND_DATA;
              rsp_nxt.length = LEN_STATUS;
              rsp_nxt.first  = {6'd0, remote_wakeup_r, self_powered_r};
            end else if (recip == RECIP_IFACE) begin
              rsp_nxt.kind   = KIND_DATA;
              rsp_nxt.length = LEN_STATUS;
            end else if (recip == RECIP_ENDPOINT && slot_ok) begin
              rsp_nxt.kind   = KIND_DATA;
              rsp_nxt.length = LEN_STATUS;
              rsp_nxt.first  = {7'd0, halt_r[slot]};
            end
          end
        end
        REQ_CLEAR_FEATURE: begin
          if (recip == RECIP_DEVICE && req_value_r == FEAT_REMOTE_WAKEUP) begin
            remote_wakeup_nxt = 1'b0;
            rsp_nxt.kind      = KIND_ACK;
          end else if (recip == RECIP_ENDPOINT && req_value_r == FEAT_ENDPOINT_HALT
                       && slot_ok) begin
            halt_nxt[slot] = 1'b0;
            rsp_nxt.kind   = KIND_ACK;
          end
        end
        REQ_SET_FEATURE: begin
          if (recip == RECIP_DEVICE) begin
            if (req_value_r == FEAT_REMOTE_WAKEUP) begin
              remote_wakeup_nxt = 1'b1;
              rsp_nxt.kind      = KIND_ACK;
            end else if (req_value_r == FEAT_TEST_MODE) begin
              // test mode: acknowledge only
              rsp_nxt.kind = KIND_ACK;
            end
          end else if (recip == RECIP_ENDPOINT && req_value_r == FEAT_ENDPOINT_HALT
                       && slot_ok) begin
            // halting an endpoint also resets its data toggle
            halt_nxt[slot]          = 1'b1;
            rsp_nxt.kind            = KIND_ACK;
            rsp_nxt.toggle_reset    = 1'b1;
            rsp_nxt.toggle_endpoint = req_index_r;
          end
        end
        REQ_SET_ADDRESS: begin
          rsp_nxt.kind = KIND_ACK;
        end
        REQ_GET_DESCRIPTOR: begin
          // direction and recipient are not checked
          rsp_nxt.kind = KIND_HANDOFF;
        end
        REQ_GET_CONFIG: begin
          rsp_nxt.kind   = KIND_DATA;
          rsp_nxt.length = LEN_BYTE;
          rsp_nxt.first  = config_number_r;
        end
        REQ_SET_CONFIG: begin
          if (req_value_r == config_number_r) begin
            rsp_nxt.kind = KIND_ACK;
          end
        end
        REQ_GET_INTERFACE: begin
          if (req_index_r == iface_number_r) begin
            rsp_nxt.kind   = KIND_DATA;
            rsp_nxt.length = LEN_BYTE;
            rsp_nxt.first  = alt_setting_r;
          end
        end
        REQ_SET_INTERFACE: begin
          // restart the data-in endpoint: clear busy and reset its toggle
          if (req_index_r == iface_number_r && req_value_r == alt_setting_r) begin
            rsp_nxt.kind              = KIND_ACK;
            rsp_nxt.in_endpoint_reset = 1'b1;
            rsp_nxt.toggle_reset      = 1'b1;
            rsp_nxt.toggle_endpoint   = in_ep_address_r;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State commits only when the request moves into the result register, so
  // each request sees the state left by the one before it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remote_wakeup_r <= 1'b0;
      halt_r          <= '0;
    end else if (advance) begin
      remote_wakeup_r <= remote_wakeup_nxt;
      halt_r          <= halt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on advance, drop once taken, hold while stalled.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_valid_r <= 1'b0;
    end else if (advance) begin
      rsp_valid_r <= 1'b1;
    end else if (!out_stall) begin
      rsp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid             = rsp_valid_r;
  assign out_reply_kind        = rsp_r.kind;
  assign out_reply_length      = rsp_r.length;
  assign out_reply_first       = rsp_r.first;
  assign out_reply_second      = 8'd0;
  assign out_toggle_reset      = rsp_r.toggle_reset;
  assign out_toggle_endpoint   = rsp_r.toggle_endpoint;
  assign out_in_endpoint_reset = rsp_r.in_endpoint_reset;

endmodule

// ----- design/usbsrr_checker.sv -----
// Port-level checks for the USB standard request responder, bound to its top level.
// Depends on usbsrr_pkg and usb_standard_request_responder.
`timescale 1ns / 1ps

module usbsrr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_reply_kind,
  input logic [1:0] out_reply_length,
  input logic [7:0] out_reply_first,
  input logic [7:0] out_reply_second,
  input logic       out_toggle_reset,
  input logic [7:0] out_toggle_endpoint,
  input logic       out_in_endpoint_reset
);

  import usbsrr_pkg::*;

  // A stalled request carries nothing else.
  ast_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reply_kind == KIND_STALL) |->
      (out_reply_length == LEN_NONE && out_reply_first == 8'd0 &&
       !out_toggle_reset && !out_in_endpoint_reset))
    else $error("stall reply carries data or strobes");

  // Reply bytes only on data replies; the second byte is always zero.
  ast_length_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reply_second == 8'd0 &&
      ((out_reply_kind == KIND_DATA) == (out_reply_length != LEN_NONE))))
    else $error("reply length does not match reply kind");

  // Endpoint restart always comes with a toggle reset on an acknowledge.
  ast_in_ep_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_endpoint_reset) |->
      (out_toggle_reset && out_reply_kind == KIND_ACK))
    else $error("in-endpoint reset without toggle reset or acknowledge");

  // Toggle endpoint is zero when no toggle reset is asked for.
  ast_toggle_ep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_toggle_reset) |-> (out_toggle_endpoint == 8'd0))
    else $error("toggle endpoint set without toggle reset");

  // A stalled reply holds.
  ast_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_reply_kind) && $stable(out_reply_first) &&
       $stable(out_toggle_endpoint)))
    else $error("stalled reply changed");

endmodule

bind usb_standard_request_responder usbsrr_checker u_usbsrr_checker (.*);
